>>> rtl/core/rlt_pkg.sv
// Package for the reply line tokenizer core.
// Holds character codes, field widths and the result record type.
// Depends on nothing; imported by reply_line_tokenizer_core.
`timescale 1ns / 1ps

package rlt_pkg;

   // Default capacity of one element, in characters (legal range 1 to 8).
   localparam int MAX_CHARS_DEF = 8;

   // Fixed field widths of the channels.
   localparam int CHAR_W = 8;
   localparam int LEN_W  = 4;
   localparam int SLOTS  = 8;
   localparam int ELEM_W = CHAR_W * SLOTS;

   // Character codes that steer the parser.
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CH_QUERY = 8'h3F;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   // One finished line: both elements, zero padded, with their lengths.
   typedef struct packed {
      logic [ELEM_W-1:0] first_chars;
      logic [LEN_W-1:0]  first_len;
      logic [ELEM_W-1:0] second_chars;
      logic [LEN_W-1:0]  second_len;
   } rlt_rsp_type;

endpackage

>>> rtl/core/reply_line_tokenizer_core.sv
// Reply line tokenizer core: splits a received text line into two elements.
// Depends on rlt_pkg for character codes, widths and the result record.
`timescale 1ns / 1ps

// The core takes one received byte per transfer and returns one result per
// completed line whose first element is not empty. The parser state is
// updated in the cycle the byte is accepted, and a line result is registered
// before it reaches the rsp_ port. A byte is accepted in every cycle while
// req_stall is low; a two-deep output buffer (result register plus skid
// register) lets input keep flowing while a result waits, and req_stall rises
// only when both are full. Up to MAX_CHARS characters are held per element;
// a longer element, a comma in the wrong place or a '#' makes the core ignore
// the rest of the line. A '?' skips bytes up to the next space.
module reply_line_tokenizer_core
   import rlt_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ELEM_W-1:0] rsp_first_chars,
   output logic [LEN_W-1:0]  rsp_first_len,
   output logic [ELEM_W-1:0] rsp_second_chars,
   output logic [LEN_W-1:0]  rsp_second_len
);

   // Parser state.
   logic              skip_ff, skip_in;
   logic              await_ff, await_in;
   logic              sel_ff, sel_in;
   logic [LEN_W-1:0]  count_ff [2];
   logic [LEN_W-1:0]  count_in [2];
   logic [CHAR_W-1:0] store_ff [2][MAX_CHARS];
   logic [CHAR_W-1:0] store_in [2][MAX_CHARS];

   // Output buffer.
   logic              out_valid_ff, out_valid_in;
   rlt_rsp_type       out_ff, out_in;
   logic              skid_valid_ff, skid_valid_in;
   rlt_rsp_type       skid_ff, skid_in;

   logic              req_fire;
   logic              produce;
   logic              wipe;
   logic [LEN_W-1:0]  cur_len;
   logic              is_num;
   rlt_rsp_type       line_rsp;

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign is_num    = req_rx_byte inside {[CH_ZERO:CH_NINE], CH_DOT, CH_DASH};
   assign cur_len   = count_ff[sel_ff];

   // Pack both elements, first character in the low byte, zero padded.
   for (genvar i = 0; i < SLOTS; i++) begin : g_pack
      if (i < MAX_CHARS) begin : g_used
         assign line_rsp.first_chars[i*CHAR_W +: CHAR_W]  = store_ff[0][i];
         assign line_rsp.second_chars[i*CHAR_W +: CHAR_W] = store_ff[1][i];
      end else begin : g_pad
         assign line_rsp.first_chars[i*CHAR_W +: CHAR_W]  = '0;
         assign line_rsp.second_chars[i*CHAR_W +: CHAR_W] = '0;
      end
   end
   assign line_rsp.first_len  = count_ff[0];
   assign line_rsp.second_len = count_ff[1];

   // Per-byte parser update, in order of priority.
   always_comb begin
      skip_in  = skip_ff;
      await_in = await_ff;
      sel_in   = sel_ff;
      count_in = count_ff;
      store_in = store_ff;
      wipe     = 1'b0;
      produce  = 1'b0;
      if (req_fire) begin
         if (req_rx_byte == CH_CR || req_rx_byte == CH_LF) begin
            produce  = (count_ff[0] != '0);
            wipe     = 1'b1;
            skip_in  = 1'b0;
            await_in = 1'b0;
         end else if (req_rx_byte == CH_HASH || skip_ff) begin
            skip_in = 1'b1;
         end else if (req_rx_byte == CH_QUERY) begin
            await_in = 1'b1;
         end else if (await_ff) begin
            if (req_rx_byte == CH_SPACE) begin
               await_in = 1'b0;
            end
         end else if (req_rx_byte == CH_COMMA) begin
            if (!sel_ff && count_ff[0] != '0) begin
               sel_in = 1'b1;
            end else begin
               wipe    = 1'b1;
               skip_in = 1'b1;
            end
         end else if (is_num) begin
            if (cur_len >= LEN_W'(MAX_CHARS)) begin
               wipe    = 1'b1;
               skip_in = 1'b1;
            end else begin
               for (int i = 0; i < MAX_CHARS; i++) begin
                  if (cur_len == LEN_W'(i)) begin
                     store_in[sel_ff][i] = req_rx_byte;
                  end
               end
               count_in[sel_ff] = cur_len + LEN_W'(1);
            end
         end
      end
      // Clearing the elements overrides any store above.
      if (wipe) begin
         sel_in = 1'b0;
         for (int e = 0; e < 2; e++) begin
            count_in[e] = '0;
            for (int i = 0; i < MAX_CHARS; i++) begin
               store_in[e][i] = '0;
            end
         end
      end
   end

   // Output buffer: the result register drains first, the skid register
   // catches a new line result while the result register is stalled.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = produce;
            out_in       = line_rsp;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_in       = line_rsp;
      end
   end

   // Control and parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff       <= 1'b0;
         await_ff      <= 1'b0;
         sel_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         for (int e = 0; e < 2; e++) begin
            count_ff[e] <= '0;
            for (int i = 0; i < MAX_CHARS; i++) begin
               store_ff[e][i] <= '0;
            end
         end
      end else begin
         skip_ff       <= skip_in;
         await_ff      <= await_in;
         sel_ff        <= sel_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         count_ff      <= count_in;
         store_ff      <= store_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_first_chars  = out_ff.first_chars;
   assign rsp_first_len    = out_ff.first_len;
   assign rsp_second_chars = out_ff.second_chars;
   assign rsp_second_len   = out_ff.second_len;

endmodule
